[hw/rtl/rrt_pkg.sv]
// rrt_pkg: sizes, operation and event codes, and shared types of the
// round-robin reference table. No dependencies.
`default_nettype none

package rrt_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int FUNC_W  = 3;
  localparam int HDL_W   = 32;
  localparam int OWN_W   = 16;
  localparam int SLOT_W  = 6;
  localparam int SIZE_W  = 7;
  localparam int BATCH_W = 7;
  localparam int EV_W    = 2;

  localparam logic [FUNC_W-1:0] FN_INSERT      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PURGE_ENTRY = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PURGE_OWNER = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PURGE_SOME  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESIZE      = 3'd4;

  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_INSERT  = 2'd1;
  localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;

  localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd10;

  // one result word, less the last/more_left marks
  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [SLOT_W-1:0] slot;
    logic [HDL_W-1:0]  out_handle;
    logic              evicted;
    logic [SIZE_W-1:0] entries_left;
  } res_t;

  // sequencer -> result buffer
  typedef struct packed {
    logic push;       // new result, last mark not yet known
    logic flush;      // item done: send held result (or res) marked last
    logic more_left;
    res_t res;
  } buf_ctl_t;

  // result buffer -> sequencer
  typedef struct packed {
    logic out_free;   // output register can load this cycle
    logic pend_v;     // a result is held back
  } buf_sts_t;

endpackage

`default_nettype wire

[hw/rtl/rrt_if.sv]
// rrt_if: valid/ready channels of the round-robin reference table
// (request, result, configuration). Depends on rrt_pkg.
`default_nettype none

interface rrt_in_if import rrt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [HDL_W-1:0]  handle;
  logic [OWN_W-1:0]  owner_id;
  logic [SLOT_W-1:0] held_slot;
  logic              is_cached;
  logic [SIZE_W-1:0] new_size;

  modport source (output valid, func, handle, owner_id, held_slot, is_cached, new_size,
                  input ready);
  modport sink   (input valid, func, handle, owner_id, held_slot, is_cached, new_size,
                  output ready);
endinterface

interface rrt_out_if import rrt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic [SLOT_W-1:0] slot;
  logic [HDL_W-1:0]  out_handle;
  logic              evicted;
  logic [SIZE_W-1:0] entries_left;
  logic              more_left;
  logic              last;

  modport source (output valid, event_res, slot, out_handle, evicted, entries_left,
                         more_left, last,
                  input ready);
  modport sink   (input valid, event_res, slot, out_handle, evicted, entries_left,
                        more_left, last,
                  output ready);
endinterface

interface rrt_cfg_if import rrt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BATCH_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/rrt_result_buf.sv]
// rrt_result_buf: holds back one result until the next shows up or the
// item ends, so the final word can carry last; drives the result channel.
// Depends on rrt_pkg and rrt_if.
`default_nettype none

module rrt_result_buf import rrt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire buf_ctl_t ctl,
  output buf_sts_t      sts,
  rrt_out_if.source     out_ch
);

  logic pend_v_r, pend_v_nxt;
  res_t pend_r, pend_nxt;
  logic out_v_r, out_v_nxt;
  res_t out_r, out_nxt;
  logic last_r, last_nxt;
  logic more_r, more_nxt;

  assign sts.out_free = !out_v_r || out_ch.ready;
  assign sts.pend_v   = pend_v_r;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    out_nxt    = out_r;
    last_nxt   = last_r;
    more_nxt   = more_r;
    if (ctl.push) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
        last_nxt  = 1'b0;
        more_nxt  = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = ctl.res;
    end else if (ctl.flush) begin
      out_v_nxt  = 1'b1;
      out_nxt    = pend_v_r ? pend_r : ctl.res;
      last_nxt   = 1'b1;
      more_nxt   = ctl.more_left;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
    more_r <= more_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.event_res    = out_r.event_res;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.out_handle   = out_r.out_handle;
  assign out_ch.evicted      = out_r.evicted;
  assign out_ch.entries_left = out_r.entries_left;
  assign out_ch.more_left    = more_r;
  assign out_ch.last         = last_r;

endmodule

`default_nettype wire

[hw/rtl/round_robin_reference_table.sv]
// round_robin_reference_table: slot table of object handles with owner tags
// and round-robin replacement. Depends on rrt_pkg, rrt_if, rrt_result_buf.
//
// One request word is taken at a time; the next is taken once the last
// result word of the current one sits in the output register, so a waiting
// result does not hold off the next request. Handle and owner live in a
// single-port synchronous store with registered read data; every slot visited
// passes through a read state and an evaluate state. After the accept and
// setup states, an insert or a purge-entry that reads its slot visits that
// slot; purge-owner every slot of the active size, resize the slots from the
// new to the old size when shrinking (none otherwise), purge-some purge_batch
// slots (none when the table is empty, the size is 0 or the batch is 0); a
// final state sends the last word. Ignored requests and unknown codes visit
// no slot. A stalled result port holds the walk in its evaluate or final
// state. Slot valid bits are flops cleared at reset, so there is no clearing
// pass. Every request yields at least one word; last marks the final one,
// more_left is set on the final word of a purge-some that leaves occupied
// slots. The cfg port (purge_batch) is always ready.
`default_nettype none

module round_robin_reference_table import rrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rrt_in_if.sink    in_ch,
  rrt_out_if.source out_ch,
  rrt_cfg_if.sink   cfg_ch
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_RD    = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [HDL_W-1:0] handle;
    logic [OWN_W-1:0] owner;
  } entry_t;

  // next round-robin position, wrapping at the active size
  function automatic logic [IDX_W-1:0] adv_slot(input logic [IDX_W-1:0] s,
                                                input logic [CNT_W-1:0] act);
    logic [CNT_W-1:0] n;
    n = CNT_W'(s) + CNT_W'(1);
    if (n >= act) return '0;
    return n[IDX_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  // latched request word
  logic [FUNC_W-1:0] func_r;
  logic [HDL_W-1:0]  handle_r;
  logic [OWN_W-1:0]  owner_r;
  logic [SLOT_W-1:0] held_r;
  logic              cached_r;
  logic [CNT_W-1:0]  req_r;    // saturated new size

  // table state
  logic [DEPTH-1:0]   valid_r, valid_nxt;
  logic [IDX_W-1:0]   next_r, next_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [CNT_W-1:0]   act_r, act_nxt;
  logic [BATCH_W-1:0] batch_r;

  // walk control
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic [BATCH_W-1:0] cnt_r, cnt_nxt;

  // handle/owner store
  entry_t mem [DEPTH];
  entry_t rdata_r;
  logic   mem_re, mem_we;

  buf_ctl_t ctl;
  buf_sts_t sts;

  logic             in_fire;
  logic             cur_v;
  logic             push, rel, stall, scan_end;
  logic [CNT_W-1:0] occ_dec, occ_ins;
  res_t             nochg_res, rel_res, ins_res;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // request latch; new_size above the table saturates
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_ch.func;
      handle_r <= in_ch.handle;
      owner_r  <= in_ch.owner_id;
      held_r   <= in_ch.held_slot;
      cached_r <= in_ch.is_cached;
      req_r    <= (in_ch.new_size > SIZE_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                    : CNT_W'(in_ch.new_size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) batch_r <= BATCH_RESET;
    else if (cfg_ch.valid && cfg_ch.ready) batch_r <= cfg_ch.data;
  end

  // store: one address, read or write
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r] <= '{handle: handle_r, owner: owner_r};
    if (mem_re) rdata_r <= mem[idx_r];
  end

  assign cur_v    = valid_r[idx_r];
  assign occ_dec  = occ_r - CNT_W'(occ_r != '0);
  assign occ_ins  = occ_r - CNT_W'(cur_v && (occ_r != '0)) + CNT_W'(1);
  assign scan_end = (CNT_W'(idx_r) + CNT_W'(1)) >= lim_r;

  always_comb begin
    nochg_res              = '0;
    nochg_res.event_res    = EV_NONE;
    nochg_res.entries_left = SIZE_W'(occ_r);

    rel_res              = '0;
    rel_res.event_res    = EV_RELEASE;
    rel_res.slot         = SLOT_W'(idx_r);
    rel_res.out_handle   = rdata_r.handle;
    rel_res.entries_left = SIZE_W'(occ_dec);

    ins_res              = '0;
    ins_res.event_res    = EV_INSERT;
    ins_res.slot         = SLOT_W'(idx_r);
    ins_res.out_handle   = cur_v ? rdata_r.handle : '0;
    ins_res.evicted      = cur_v;
    ins_res.entries_left = SIZE_W'(occ_ins);
  end

  // what the evaluate cycle would release or push
  always_comb begin
    rel  = 1'b0;
    push = 1'b0;
    if (state_r == ST_EVAL) begin
      unique case (func_r)
        FN_INSERT:      push = 1'b1;
        FN_PURGE_ENTRY: rel  = cur_v && (rdata_r.handle == handle_r);
        FN_PURGE_OWNER: rel  = cur_v && (rdata_r.owner == owner_r);
        FN_PURGE_SOME:  rel  = cur_v;
        FN_RESIZE:      rel  = cur_v;
        default:        rel  = 1'b0;
      endcase
      push = push || rel;
    end
  end

  // a new word with one already held needs the output register
  assign stall = push && sts.pend_v && !sts.out_free;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    next_nxt  = next_r;
    occ_nxt   = occ_r;
    act_nxt   = act_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    cnt_nxt   = cnt_r;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    ctl       = '0;
    ctl.res   = nochg_res;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SETUP;
      end

      ST_SETUP: begin
        state_nxt = ST_FIN;
        unique case (func_r)
          FN_INSERT: begin
            if (!cached_r && act_r != '0) begin
              idx_nxt   = next_r;
              state_nxt = ST_RD;
            end
          end
          FN_PURGE_ENTRY: begin
            if (cached_r) begin
              idx_nxt   = IDX_W'(held_r);
              state_nxt = ST_RD;
            end
          end
          FN_PURGE_OWNER: begin
            if (act_r != '0) begin
              idx_nxt   = '0;
              lim_nxt   = act_r;
              state_nxt = ST_RD;
            end
          end
          FN_PURGE_SOME: begin
            if (occ_r != '0 && act_r != '0 && batch_r != '0) begin
              idx_nxt   = next_r;
              cnt_nxt   = batch_r;
              state_nxt = ST_RD;
            end
          end
          FN_RESIZE: begin
            // shrink walks the dropped slots under the old size
            if (req_r < act_r) begin
              idx_nxt   = req_r[IDX_W-1:0];
              lim_nxt   = act_r;
              state_nxt = ST_RD;
              if (CNT_W'(next_r) >= req_r) next_nxt = '0;
            end
            act_nxt = req_r;
          end
          default: state_nxt = ST_FIN;
        endcase
      end

      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        if (!stall) begin
          ctl.push = push;
          ctl.res  = (func_r == FN_INSERT) ? ins_res : rel_res;
          if (rel) begin
            valid_nxt[idx_r] = 1'b0;
            occ_nxt          = occ_dec;
          end
          unique case (func_r)
            FN_INSERT: begin
              mem_we           = 1'b1;
              valid_nxt[idx_r] = 1'b1;
              occ_nxt          = occ_ins;
              next_nxt         = adv_slot(next_r, act_r);
              state_nxt        = ST_FIN;
            end
            FN_PURGE_SOME: begin
              next_nxt  = adv_slot(next_r, act_r);
              idx_nxt   = adv_slot(next_r, act_r);
              cnt_nxt   = cnt_r - BATCH_W'(1);
              state_nxt = (cnt_r == BATCH_W'(1)) ? ST_FIN : ST_RD;
            end
            FN_PURGE_OWNER, FN_RESIZE: begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = scan_end ? ST_FIN : ST_RD;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_FIN: begin
        ctl.flush     = sts.out_free;
        ctl.more_left = (func_r == FN_PURGE_SOME) && (occ_r != '0);
        if (sts.out_free) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      next_r  <= '0;
      occ_r   <= '0;
      act_r   <= CNT_W'(DEPTH);
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      next_r  <= next_nxt;
      occ_r   <= occ_nxt;
      act_r   <= act_nxt;
    end
    idx_r <= idx_nxt;
    lim_r <= lim_nxt;
    cnt_r <= cnt_nxt;
  end

  rrt_result_buf u_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sts    (sts),
    .out_ch (out_ch)
  );

  // occupancy count tracks the valid bits
  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == CNT_W'($countones(valid_r)))
    else $error("occupancy count out of step with valid bits");

  // insert position stays inside the active table
  a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(next_r) < act_r) || (act_r == '0 && next_r == '0))
    else $error("next slot outside active size");

  // store written only by an insert being evaluated
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_EVAL && func_r == FN_INSERT && !stall))
    else $error("store write outside insert");

  // nothing held back once a request has finished
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && sts.out_free) |=> !sts.pend_v)
    else $error("result left pending after final word");

  // request taken only with the walk state idle and no word held back
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !sts.pend_v)
    else $error("request accepted with a result held back");

endmodule

`default_nettype wire

[test/rrt_table_checker.sv]
`timescale 1ns / 100ps
// rrt_table_checker: watches the request, result and cfg channels of the
// round-robin reference table, predicts result words and compares them.
// Depends on rrt_pkg and rrt_if.

module rrt_table_checker import rrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rrt_in_if         in_ch,
  rrt_out_if        out_ch,
  rrt_cfg_if        cfg_ch,
  output int        fail_count,
  output int        words_pending,
  output int        words_checked
);

  typedef struct packed {
    res_t body;
    logic more_left;
    logic last;
  } table_word_t;

  // shadow of the slot store and its pointers
  logic             slot_used   [DEPTH];
  logic [HDL_W-1:0] slot_handle [DEPTH];
  logic [OWN_W-1:0] slot_tag    [DEPTH];
  int               next_idx;
  int               occupied;
  int               active_len;
  logic [BATCH_W-1:0] batch_len;

  table_word_t expected_words[$];
  table_word_t head_word;

  function automatic void clear_shadow();
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i]   = 1'b0;
      slot_handle[i] = '0;
      slot_tag[i]    = '0;
    end
    next_idx   = 0;
    occupied   = 0;
    active_len = DEPTH;
    batch_len  = BATCH_RESET;
    expected_words.delete();
  endfunction

  function automatic void queue_word(input logic [EV_W-1:0] ev, input int s,
                                     input logic [HDL_W-1:0] h, input logic evict);
    table_word_t w;
    w.body.event_res    = ev;
    w.body.slot         = s[SLOT_W-1:0];
    w.body.out_handle   = h;
    w.body.evicted      = evict;
    w.body.entries_left = SIZE_W'(occupied);
    w.more_left         = 1'b0;
    w.last              = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void free_slot(input int s);
    slot_used[s] = 1'b0;
    if (occupied > 0) occupied--;
    queue_word(EV_RELEASE, s, slot_handle[s], 1'b0);
  endfunction

  function automatic void step_index();
    int n;
    n = next_idx + 1;
    if (n >= active_len || n >= DEPTH) n = 0;
    next_idx = n;
  endfunction

  // words caused by one request, appended to expected_words
  function automatic void predict_request(input logic [FUNC_W-1:0] fn,
                                          input logic [HDL_W-1:0] h,
                                          input logic [OWN_W-1:0] own,
                                          input logic [SLOT_W-1:0] held,
                                          input logic cached,
                                          input logic [SIZE_W-1:0] req);
    int          n_before;
    int          s;
    int          req_i;
    bit          sweep;
    logic [HDL_W-1:0] old_h;
    logic        evict;
    table_word_t tail;
    n_before = expected_words.size();
    sweep = 1'b0;
    case (fn)
      FN_INSERT: begin
        if (!cached && active_len != 0) begin
          s = next_idx;
          old_h = '0;
          evict = 1'b0;
          if (slot_used[s]) begin
            old_h = slot_handle[s];
            evict = 1'b1;
            if (occupied > 0) occupied--;
          end
          slot_used[s]   = 1'b1;
          slot_handle[s] = h;
          slot_tag[s]    = own;
          occupied++;
          step_index();
          queue_word(EV_INSERT, s, old_h, evict);
        end
      end
      FN_PURGE_ENTRY: begin
        if (cached && slot_used[held] && slot_handle[held] == h) free_slot(int'(held));
      end
      FN_PURGE_OWNER: begin
        for (s = 0; s < active_len && s < DEPTH; s++)
          if (slot_used[s] && slot_tag[s] == own) free_slot(s);
      end
      FN_PURGE_SOME: begin
        sweep = 1'b1;
        if (occupied != 0 && active_len != 0) begin
          for (int i = 0; i < int'(batch_len); i++) begin
            s = next_idx;
            if (slot_used[s]) free_slot(s);
            step_index();
          end
        end
      end
      FN_RESIZE: begin
        req_i = (int'(req) > DEPTH) ? DEPTH : int'(req);
        if (req_i < active_len) begin
          for (s = req_i; s < active_len && s < DEPTH; s++)
            if (slot_used[s]) free_slot(s);
          if (next_idx >= req_i) next_idx = 0;
        end
        active_len = req_i;
      end
      default: ;
    endcase
    if (expected_words.size() == n_before) queue_word(EV_NONE, 0, '0, 1'b0);
    tail = expected_words.pop_back();
    tail.last = 1'b1;
    if (sweep && occupied != 0) tail.more_left = 1'b1;
    expected_words.push_back(tail);
  endfunction

  function automatic void check_field(input string name, input logic [HDL_W-1:0] want,
                                      input logic [HDL_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_checked = 0;
    clear_shadow();
  end

  // requests are predicted before results are compared, so a word of an
  // earlier request at the same edge still meets its own expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_shadow();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) batch_len = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        predict_request(in_ch.func, in_ch.handle, in_ch.owner_id, in_ch.held_slot,
                        in_ch.is_cached, in_ch.new_size);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word: expected none, actual event %0d slot %0d",
                   $time, out_ch.event_res, out_ch.slot);
        end else begin
          head_word = expected_words.pop_front();
          words_checked++;
          check_field("event_res", HDL_W'(head_word.body.event_res), HDL_W'(out_ch.event_res));
          check_field("slot", HDL_W'(head_word.body.slot), HDL_W'(out_ch.slot));
          check_field("out_handle", head_word.body.out_handle, out_ch.out_handle);
          check_field("evicted", HDL_W'(head_word.body.evicted), HDL_W'(out_ch.evicted));
          check_field("entries_left", HDL_W'(head_word.body.entries_left),
                      HDL_W'(out_ch.entries_left));
          check_field("more_left", HDL_W'(head_word.more_left), HDL_W'(out_ch.more_left));
          check_field("last", HDL_W'(head_word.last), HDL_W'(out_ch.last));
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

[test/round_robin_reference_table_test.sv]
`timescale 1ns / 100ps
// round_robin_reference_table_test: stimulus and verdict for the round-robin
// reference table. Depends on rrt_pkg, rrt_if, the block and rrt_table_checker.

module round_robin_reference_table_test;
  import rrt_pkg::*;

  // func codes the block does not define; they must give one no-change word
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;

  logic clk = 1'b0;
  logic rst_n;

  always #10 clk = ~clk;

  rrt_in_if  in_ch();
  rrt_out_if out_ch();
  rrt_cfg_if cfg_ch();

  int fail_count;
  int words_pending;
  int words_checked;

  round_robin_reference_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rrt_table_checker i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked)
  );

  // ---------------------------------------------------------------------
  // Stimulus-side view of the table. Only used to aim purge-entry requests
  // at slots that really hold the handle; the checker does the predicting.
  // Inserted handles are matched to insert result words in order, which
  // holds as long as inserts that are ignored (cached, or size 0) are not
  // queued here.
  // ---------------------------------------------------------------------
  bit               hint_used   [DEPTH];
  logic [HDL_W-1:0] hint_handle [DEPTH];
  logic [HDL_W-1:0] inserted_handles[$];
  int               size_view;
  int               n_requests;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.event_res == EV_INSERT && inserted_handles.size() != 0) begin
        hint_used[out_ch.slot]   = 1'b1;
        hint_handle[out_ch.slot] = inserted_handles.pop_front();
      end else if (out_ch.event_res == EV_RELEASE) begin
        hint_used[out_ch.slot] = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result port: alternates ready runs and stall runs of random length.
  // rx_stall_on low gives a stretch with the port always ready.
  // ---------------------------------------------------------------------
  bit rx_stall_on;
  bit rx_run_ready;
  int rx_left;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_run_ready = !rx_run_ready;
      rx_left = rx_run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
    end
    rx_left--;
    out_ch.ready = rx_stall_on ? rx_run_ready : 1'b1;
  end

  // ---------------------------------------------------------------------
  // Request driver. Fields change at the falling edge; the word is taken at
  // the first rising edge with ready high. valid is left high on return, the
  // next call (or a gap) decides its value at the next falling edge.
  // ---------------------------------------------------------------------
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [HDL_W-1:0] h,
                              input logic [OWN_W-1:0] own, input logic [SLOT_W-1:0] held,
                              input logic cached, input logic [SIZE_W-1:0] sz);
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.func      = fn;
    in_ch.handle    = h;
    in_ch.owner_id  = own;
    in_ch.held_slot = held;
    in_ch.is_cached = cached;
    in_ch.new_size  = sz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_requests++;
    if (fn == FN_INSERT && !cached && size_view != 0) inserted_handles.push_back(h);
    if (fn == FN_RESIZE) size_view = (int'(sz) > DEPTH) ? DEPTH : int'(sz);
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // hold requests back until every expected word has come out
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  task automatic write_batch(input logic [BATCH_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // mostly a handful of owners so sweeps hit, now and then any tag
  function automatic logic [OWN_W-1:0] pick_owner();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return OWN_W'($urandom_range(0, 5));
    if (r == 8) return OWN_W'($urandom);
    return '1;
  endfunction

  // sizes stay large most of the time so the table fills and evicts
  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SIZE_W'(DEPTH);
    if (r < 60) return SIZE_W'($urandom_range(32, DEPTH));
    if (r < 75) return SIZE_W'($urandom_range(DEPTH + 1, 127));
    if (r < 90) return SIZE_W'($urandom_range(0, 8));
    return SIZE_W'($urandom_range(0, DEPTH));
  endfunction

  task automatic send_random_request();
    int               pick;
    int               s;
    int               k;
    bit               found;
    logic [FUNC_W-1:0] fn;
    logic [HDL_W-1:0]  h;
    logic [OWN_W-1:0]  own;
    logic [SLOT_W-1:0] held;
    logic              cached;
    logic [SIZE_W-1:0] sz;
    pick   = $urandom_range(0, 99);
    h      = $urandom;
    own    = pick_owner();
    held   = SLOT_W'($urandom);
    cached = 1'($urandom);
    sz     = SIZE_W'($urandom);
    if (pick < 50) begin
      fn = FN_INSERT;
      cached = ($urandom_range(0, 9) == 0);
    end else if (pick < 65) begin
      fn = FN_PURGE_ENTRY;
      // usually a well-formed purge of a live slot, sometimes noise
      if ($urandom_range(0, 3) != 0) begin
        s = $urandom_range(0, DEPTH - 1);
        found = 1'b0;
        for (k = 0; k < DEPTH && !found; k++)
          if (hint_used[(s + k) % DEPTH]) begin
            held  = SLOT_W'((s + k) % DEPTH);
            found = 1'b1;
          end
        if (found) begin
          h = hint_handle[held];
          cached = ($urandom_range(0, 7) != 0);
        end
      end
    end else if (pick < 75) begin
      fn = FN_PURGE_OWNER;
    end else if (pick < 85) begin
      fn = FN_PURGE_SOME;
    end else if (pick < 95) begin
      fn = FN_RESIZE;
      sz = pick_size();
    end else begin
      fn = FN_UNUSED_LO + FUNC_W'($urandom_range(0, 2));
    end
    send_request(fn, h, own, held, cached, sz);
  endtask

  // bursts of back-to-back words with random gaps between them
  task automatic run_phase(input int n, input bit with_gaps);
    int burst_left;
    burst_left = 0;
    repeat (n) begin
      if (with_gaps && burst_left == 0) begin
        idle_for($urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      if ($urandom_range(0, 59) == 0) drain_results();
      send_random_request();
    end
  endtask

  // edge cases first, table at full size and batch at its reset value
  task automatic directed_requests();
    send_request(FN_PURGE_SOME, '0, '0, '0, 1'b0, '0);           // purge-some, empty table
    send_request(FN_PURGE_ENTRY, '0, '0, 6'd63, 1'b1, '0);       // empty slot
    send_request(FN_INSERT, '0, '0, '0, 1'b0, '0);               // slot 0
    send_request(FN_INSERT, '1, '1, '0, 1'b0, '0);               // slot 1, all ones
    send_request(FN_INSERT, 32'h0000_1234, 16'd1, '0, 1'b1, '0); // already cached
    send_request(FN_PURGE_ENTRY, '1, '0, 6'd1, 1'b1, '0);        // hit on slot 1
    send_request(FN_PURGE_ENTRY, 32'd5, '0, 6'd0, 1'b1, '0);     // wrong handle
    send_request(FN_PURGE_ENTRY, '0, '0, 6'd0, 1'b0, '0);        // not marked cached
    send_request(FN_PURGE_OWNER, '0, '1, '0, 1'b0, '0);          // no owner hit
    send_request(FN_INSERT, 32'hA5A5_5A5A, '0, '0, 1'b0, '0);    // slot 2
    send_request(FN_PURGE_OWNER, '0, '0, '0, 1'b0, '0);          // frees slots 0 and 2
    for (int k = 0; k < 3; k++)
      send_request(FN_UNUSED_LO + FUNC_W'(k), '1, '1, '1, 1'b1, '1);
    send_request(FN_INSERT, 32'd1, 16'd1, '0, 1'b0, '0);         // slot 3
    send_request(FN_RESIZE, '0, '0, '0, 1'b0, 7'd0);             // shrink to 0, frees slot 3
    send_request(FN_INSERT, 32'd2, 16'd1, '0, 1'b0, '0);         // ignored, size 0
    send_request(FN_PURGE_SOME, '0, '0, '0, 1'b0, '0);           // size 0
    send_request(FN_RESIZE, '0, '0, '0, 1'b0, 7'd127);           // saturates to full
    send_request(FN_RESIZE, '0, '0, '0, 1'b0, 7'd3);
    send_request(FN_INSERT, 32'h10, 16'd7, '0, 1'b0, '0);
    send_request(FN_INSERT, 32'h11, 16'd7, '0, 1'b0, '0);
    send_request(FN_INSERT, 32'h12, 16'd9, '0, 1'b0, '0);
    send_request(FN_INSERT, 32'h13, 16'd7, '0, 1'b0, '0);        // wraps, evicts slot 0
    send_request(FN_PURGE_OWNER, '0, 16'd7, '0, 1'b0, '0);
    send_request(FN_PURGE_SOME, '0, '0, '0, 1'b0, '0);           // batch wraps a 3-slot table
    send_request(FN_RESIZE, '0, '0, '0, 1'b0, 7'd64);            // grow back
  endtask

  initial begin : stimulus
    logic [BATCH_W-1:0] next_batch;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FN_INSERT;
    in_ch.handle    = '0;
    in_ch.owner_id  = '0;
    in_ch.held_slot = '0;
    in_ch.is_cached = 1'b0;
    in_ch.new_size  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b1;
    rx_stall_on     = 1'b1;
    rx_run_ready    = 1'b0;
    rx_left         = 0;
    size_view       = DEPTH;
    n_requests      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_requests();

    // six phases of random words; the batch register is only written with
    // the block idle, running through the reset value, 1, 64, 127, 0 and a
    // random small value. Phase 2 runs with no gaps and no result stalls.
    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        drain_results();
        repeat (8) @(negedge clk);
        case (p)
          1:       next_batch = 7'd1;
          2:       next_batch = 7'd64;
          3:       next_batch = 7'd127;
          4:       next_batch = 7'd0;
          default: next_batch = BATCH_W'($urandom_range(2, 20));
        endcase
        write_batch(next_batch);
      end
      rx_stall_on = (p != 2);
      run_phase(47, p != 2);
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests (all functions, edge cases, six purge batch settings)",
             n_requests);
    $display("and %0d result words under bursty input and stalled output.", words_checked);
    if (fail_count == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #(20_000_000);
    $display("Timeout with %0d result words outstanding", words_pending);
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_if.sv
hw/rtl/rrt_result_buf.sv
hw/rtl/round_robin_reference_table.sv
test/rrt_table_checker.sv
test/round_robin_reference_table_test.sv
